[hdl/ltc_pkg.sv]
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int CFG_W   = 2;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD_MIN   = 8'hC0;
    localparam logic [7:0] LEAD_MAX   = 8'hC7;
    localparam logic [8:0] LATIN1_MAX = 9'h0FF;

    typedef enum logic [CFG_W-1:0] {
        CS_LOCAL  = 2'd0,
        CS_LATIN1 = 2'd1,
        CS_UTF8   = 2'd2,
        CS_UCS2   = 2'd3
    } t_charset;

    typedef enum logic [0:0] {
        CFG_SOURCE = 1'b0,
        CFG_TARGET = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ODD_UCS2    = 3'd1,
        ST_UCS2_WIDE   = 3'd2,
        ST_TRUNC       = 3'd3,
        ST_OVERLONG    = 3'd4,
        ST_NOT_LATIN1  = 3'd5,
        ST_UNSUPPORTED = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       run_last;
        logic       string_done;
    } t_out;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic       two;
        t_status    status;
        logic       eos;
    } t_entry;

    function automatic t_charset norm_cs(input t_charset cs);
        norm_cs = (cs == CS_LOCAL) ? CS_LATIN1 : cs;
    endfunction

endpackage

[hdl/ltc_front.sv]
`timescale 1ns / 1ps

module ltc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [ltc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  ltc_pkg::t_in              i_in,
    input  logic                      i_q_full,
    output logic                      o_push,
    output ltc_pkg::t_entry           o_entry
);

    ltc_pkg::t_charset r_src, r_tgt;
    logic              r_pend, n_pend;
    logic [7:0]        r_held, n_held;
    logic              r_err, n_err;

    ltc_pkg::t_charset from_cs, to_cs;
    ltc_pkg::t_status  err;
    logic              has_res;
    logic              accept;
    logic [8:0]        v;
    logic [7:0]        c;
    logic              eos;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && has_res;
    assign c       = i_in.in_byte;
    assign eos     = i_in.end_of_string;
    assign from_cs = ltc_pkg::norm_cs(r_src);
    assign to_cs   = ltc_pkg::norm_cs(r_tgt);
    assign v       = {r_held[2:0], c[5:0]};

    always_comb begin
        o_entry        = '0;
        o_entry.status = ltc_pkg::ST_OK;
        o_entry.eos    = eos;
        err            = ltc_pkg::ST_OK;
        has_res        = 1'b0;
        n_pend         = r_pend;
        n_held         = r_held;
        n_err          = r_err;
        if (!r_err) begin
            if (from_cs == to_cs) begin
                o_entry.b0 = c;
                has_res    = 1'b1;
            end else if (from_cs == ltc_pkg::CS_LATIN1 && to_cs == ltc_pkg::CS_UTF8) begin
                has_res = 1'b1;
                if (c <= ltc_pkg::ASCII_MAX) begin
                    o_entry.b0 = c;
                end else begin
                    o_entry.b0  = {6'b110000, c[7:6]};
                    o_entry.b1  = {2'b10, c[5:0]};
                    o_entry.two = 1'b1;
                end
            end else if (from_cs == ltc_pkg::CS_UTF8 && to_cs == ltc_pkg::CS_LATIN1) begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    if (v <= {1'b0, ltc_pkg::ASCII_MAX}) begin
                        err = ltc_pkg::ST_OVERLONG;
                    end else if (v > ltc_pkg::LATIN1_MAX) begin
                        err = ltc_pkg::ST_NOT_LATIN1;
                    end else begin
                        o_entry.b0 = v[7:0];
                        has_res    = 1'b1;
                    end
                end else if (c <= ltc_pkg::ASCII_MAX) begin
                    o_entry.b0 = c;
                    has_res    = 1'b1;
                end else if (c inside {[ltc_pkg::LEAD_MIN:ltc_pkg::LEAD_MAX]}) begin
                    if (eos) begin
                        err = ltc_pkg::ST_TRUNC;
                    end else begin
                        n_pend = 1'b1;
                        n_held = c;
                    end
                end else begin
                    err = ltc_pkg::ST_NOT_LATIN1;
                end
            end else if (from_cs == ltc_pkg::CS_UCS2 && to_cs == ltc_pkg::CS_LATIN1) begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    if (r_held != 8'h00) begin
                        err = ltc_pkg::ST_UCS2_WIDE;
                    end else begin
                        o_entry.b0 = c;
                        has_res    = 1'b1;
                    end
                end else if (eos) begin
                    err = ltc_pkg::ST_ODD_UCS2;
                end else begin
                    n_pend = 1'b1;
                    n_held = c;
                end
            end else begin
                err = ltc_pkg::ST_UNSUPPORTED;
            end
            if (err != ltc_pkg::ST_OK) begin
                o_entry.b0     = 8'h00;
                o_entry.b1     = 8'h00;
                o_entry.two    = 1'b0;
                o_entry.status = err;
                has_res        = 1'b1;
                n_err          = 1'b1;
            end
        end
        if (eos) begin
            n_pend = 1'b0;
            n_err  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src  <= ltc_pkg::CS_LOCAL;
            r_tgt  <= ltc_pkg::CS_LOCAL;
            r_pend <= 1'b0;
            r_held <= 8'h00;
            r_err  <= 1'b0;
        end else if (i_cfg_we) begin
            case (ltc_pkg::t_cfg_idx'(i_cfg_idx))
                ltc_pkg::CFG_SOURCE: r_src <= ltc_pkg::t_charset'(i_cfg_data);
                ltc_pkg::CFG_TARGET: r_tgt <= ltc_pkg::t_charset'(i_cfg_data);
                default: ;
            endcase
            r_pend <= 1'b0;
            r_err  <= 1'b0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_held <= n_held;
            r_err  <= n_err;
        end
    end

endmodule

[hdl/ltc_queue.sv]
`timescale 1ns / 1ps

module ltc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ltc_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output ltc_pkg::t_entry o_head
);

    localparam logic [ltc_pkg::QPTR_W-1:0] PTR_LAST = ltc_pkg::QPTR_W'(ltc_pkg::QDEPTH - 1);
    localparam logic [ltc_pkg::QCNT_W-1:0] CNT_FULL = ltc_pkg::QCNT_W'(ltc_pkg::QDEPTH);

    ltc_pkg::t_entry               r_mem [ltc_pkg::QDEPTH];
    logic [ltc_pkg::QPTR_W-1:0]    r_wr, n_wr;
    logic [ltc_pkg::QPTR_W-1:0]    r_rd, n_rd;
    logic [ltc_pkg::QCNT_W-1:0]    r_count, n_count;

    assign o_full       = (r_count == CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_head_valid))
        else $error("pop from empty queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

[hdl/ltc_back.sv]
`timescale 1ns / 1ps

module ltc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  ltc_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output ltc_pkg::t_out   o_out
);

    logic          r_valid, n_valid;
    logic          r_phase, n_phase;
    ltc_pkg::t_out r_out, n_out;
    logic          take;

    assign take    = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_out   = r_out;

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_out   = r_out;
        o_pop   = 1'b0;
        if (take) begin
            if (i_head_valid) begin
                n_valid = 1'b1;
                if (i_head.two && !r_phase) begin
                    n_out.out_byte    = i_head.b0;
                    n_out.status      = ltc_pkg::ST_OK;
                    n_out.run_last    = 1'b0;
                    n_out.string_done = 1'b0;
                    n_phase           = 1'b1;
                end else begin
                    n_out.out_byte    = r_phase ? i_head.b1 : i_head.b0;
                    n_out.status      = i_head.status;
                    n_out.run_last    = 1'b1;
                    n_out.string_done = i_head.eos;
                    n_phase           = 1'b0;
                    o_pop             = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef ASSERT_OFF
    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_head_valid && i_head.two))
        else $error("second byte pending without a two-byte head");

    a_phase_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_valid && !r_out.run_last))
        else $error("second byte pending after a closing result");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.string_done) |-> r_out.run_last)
        else $error("string end flagged on a non-final result");
`endif

endmodule

[hdl/latin1_utf8_ucs2_transcoder.sv]
`timescale 1ns / 1ps

// Byte-stream transcoder: Latin-1 (or local) to UTF-8, UTF-8 or UCS-2 to
// Latin-1, or pass-through when both charsets match. Input bytes are
// accepted one per cycle whenever the two-entry queue between the
// classifier and the output stage has room; each accepted byte is classified
// in the cycle it arrives. Results leave through a registered output, one per
// cycle while the receiver is ready. A Latin-1 byte above 0x7F bound for
// UTF-8 yields two result bytes, so the sustained rate is one item per cycle
// only for single-result traffic. Bytes dropped after an error, and the first
// byte of a UTF-8 or UCS-2 pair, give no result. Write the charset registers
// only while idle; a write starts a new string. No clearing pass after reset.

module latin1_utf8_ucs2_transcoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [ltc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  ltc_pkg::t_in              i_in,
    output logic                      o_valid,
    input  logic                      i_ready,
    output ltc_pkg::t_out             o_out
);

    logic            q_full;
    logic            push;
    logic            pop;
    logic            head_valid;
    ltc_pkg::t_entry entry;
    ltc_pkg::t_entry head;

    ltc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (entry)
    );

    ltc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    ltc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out        (o_out)
    );

endmodule
